>>> sv/tscp_pkg.sv
// Shared types, codes and constants for the text stream cursor placer.
package tscp_pkg;

  // Defaults for the grid size limits.
  localparam int MAX_ROWS_DEFAULT    = 64;
  localparam int MAX_COLUMNS_DEFAULT = 256;

  // Field widths.
  localparam int ROW_W       = 7;
  localparam int COL_W       = 9;
  localparam int WROW_W      = 6;
  localparam int WCOL_W      = 8;
  localparam int CHAR_W      = 7;
  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;

  // Register reset values.
  localparam logic [ROW_W-1:0] ROWS_RESET    = 7'd24;
  localparam logic [COL_W-1:0] COLUMNS_RESET = 9'd80;

  // Operation codes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_TEXT  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 1'b1;

  // Character codes.
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_RETURN    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [BYTE_W-1:0] CHAR_DELETE    = 8'h7F;
  localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TILDE     = 8'h7E;

  typedef struct packed {
    logic              operation;
    logic [BYTE_W-1:0] text_byte;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
  } cursor_t;

  typedef struct packed {
    logic              clear_grid;
    logic              write_valid;
    logic [WROW_W-1:0] write_row;
    logic [WCOL_W-1:0] write_column;
    logic [CHAR_W-1:0] write_char;
    cursor_t           cursor;
    logic              grid_full;
  } result_t;

endpackage

>>> sv/tscp_text_if.sv
// Channel that carries start items and text bytes into the placer.
interface tscp_text_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] text_byte;

  modport source (output valid, output operation, output text_byte, input ready);
  modport sink   (input valid, input operation, input text_byte, output ready);
endinterface

>>> sv/tscp_place_if.sv
// Channel that carries cell writes and cursor reports out of the placer.
interface tscp_place_if;
  logic       valid;
  logic       ready;
  logic       clear_grid;
  logic       write_valid;
  logic [5:0] write_row;
  logic [7:0] write_column;
  logic [6:0] write_char;
  logic [6:0] cursor_row_out;
  logic [8:0] cursor_column_out;
  logic       grid_full;

  modport source (
    output valid, output clear_grid, output write_valid, output write_row,
    output write_column, output write_char, output cursor_row_out,
    output cursor_column_out, output grid_full, input ready
  );
  modport sink (
    input valid, input clear_grid, input write_valid, input write_row,
    input write_column, input write_char, input cursor_row_out,
    input cursor_column_out, input grid_full, output ready
  );
endinterface

>>> sv/text_stream_cursor_placer_unit.sv
// Top level of the text stream cursor placer: registers, handshake and cursor state.
// Path: the input register holds an accepted transaction, then the result register its result.
// Throughput: one item per cycle while placement.ready holds; the two registers part the channels.
// The cursor register feeds back to itself through the combinational step logic.
// Reset (synchronous, active high) empties both registers, homes the cursor and loads
// 24 rows and 80 columns into the configuration registers.
module text_stream_cursor_placer_unit #(
  parameter int MAX_ROWS    = tscp_pkg::MAX_ROWS_DEFAULT,
  parameter int MAX_COLUMNS = tscp_pkg::MAX_COLUMNS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  tscp_text_if.sink                         text,
  tscp_place_if.source                      placement,
  input  logic                              cfg_write,
  input  logic [tscp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tscp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tscp_pkg::*;

  logic [ROW_W-1:0] rows_cfg;
  logic [COL_W-1:0] cols_cfg;
  logic [ROW_W-1:0] rows_eff;
  logic [COL_W-1:0] cols_eff;

  logic    in_valid;
  item_t   in_item;
  cursor_t cursor;
  logic    out_valid;
  result_t out_result;
  result_t step_result;
  logic    advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= ROWS_RESET;
      cols_cfg <= COLUMNS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROWS:    rows_cfg <= cfg_data[ROW_W-1:0];
        REG_COLUMNS: cols_cfg <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the grid size into one through the limit.
  always_comb begin
    if (rows_cfg == '0) begin
      rows_eff = 7'd1;
    end else if ({25'd0, rows_cfg} > MAX_ROWS) begin
      rows_eff = ROW_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_cfg;
    end
    if (cols_cfg == '0) begin
      cols_eff = 9'd1;
    end else if ({23'd0, cols_cfg} > MAX_COLUMNS) begin
      cols_eff = COL_W'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_cfg;
    end
  end

  // The item moves on whenever the result register is free or being emptied.
  assign advance    = in_valid && (!out_valid || placement.ready);
  assign text.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_item.operation <= text.operation;
      in_item.text_byte <= text.text_byte;
    end
  end

  tscp_step u_step (
    .item     (in_item),
    .cursor   (cursor),
    .rows_eff (rows_eff),
    .cols_eff (cols_eff),
    .result   (step_result)
  );

  // Cursor state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        cursor    <= step_result.cursor;
        out_valid <= 1'b1;
      end else if (placement.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign placement.valid             = out_valid;
  assign placement.clear_grid        = out_result.clear_grid;
  assign placement.write_valid       = out_result.write_valid;
  assign placement.write_row         = out_result.write_row;
  assign placement.write_column      = out_result.write_column;
  assign placement.write_char        = out_result.write_char;
  assign placement.cursor_row_out    = out_result.cursor.row;
  assign placement.cursor_column_out = out_result.cursor.column;
  assign placement.grid_full         = out_result.grid_full;

`ifndef NO_ASSERTIONS
  // The cursor register always matches the cursor of the newest result.
  a_cursor_tracks_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor == out_result.cursor))
    else $error("cursor register differs from the last reported cursor");

  // A start transaction never carries a cell write and homes the cursor.
  a_start_homes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.clear_grid) |->
      (!out_result.write_valid && out_result.cursor == '0))
    else $error("start result carries a write or a cursor away from home");

  // An item that moves on always lands in the result register.
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("item left the input register without a result");

  // Back pressure only while both registers are occupied.
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !text.ready |-> (in_valid && out_valid && !placement.ready))
    else $error("input stalled with a free stage");
`endif

endmodule

>>> sv/tscp_step.sv
// Cursor update and cell write decision for one item.
module tscp_step (
  input  tscp_pkg::item_t                 item,
  input  tscp_pkg::cursor_t               cursor,
  input  logic [tscp_pkg::ROW_W-1:0]      rows_eff,
  input  logic [tscp_pkg::COL_W-1:0]      cols_eff,
  output tscp_pkg::result_t               result
);
  import tscp_pkg::*;

  cursor_t           nxt;
  logic              wv;
  logic [ROW_W-1:0]  wr;
  logic [COL_W-1:0]  wc;
  logic [CHAR_W-1:0] wch;
  logic [COL_W-1:0]  col_clamped;
  logic [ROW_W-1:0]  row_wrapped;

  // Both helpers are only used where they cannot overflow their widths.
  assign col_clamped = (cursor.column > cols_eff) ? cols_eff : cursor.column;
  assign row_wrapped = cursor.row + 7'd1;

  // Decode the item against the current cursor.
  always_comb begin
    nxt = cursor;
    wv  = 1'b0;
    wr  = '0;
    wc  = '0;
    wch = '0;
    result = '0;
    if (item.operation == OP_START) begin
      result.clear_grid = 1'b1;
      nxt = '0;
    end else if (cursor.row < rows_eff) begin
      unique case (item.text_byte)
        CHAR_NEWLINE: begin
          nxt.row    = row_wrapped;
          nxt.column = '0;
        end
        CHAR_RETURN: begin
          nxt.column = '0;
        end
        CHAR_BACKSPACE, CHAR_DELETE: begin
          // Step back one cell, wrapping to the end of the previous row.
          if (cursor.column != '0) begin
            nxt.column = col_clamped - 9'd1;
            wv = 1'b1;
          end else if (cursor.row != '0) begin
            nxt.row    = cursor.row - 7'd1;
            nxt.column = cols_eff - 9'd1;
            wv = 1'b1;
          end
          if (wv) begin
            wr  = nxt.row;
            wc  = nxt.column;
            wch = CHAR_SPACE[CHAR_W-1:0];
          end
        end
        default: begin
          // Printable bytes wrap first when the row is full, then store if the new row is inside the grid.
          if (item.text_byte >= CHAR_SPACE && item.text_byte <= CHAR_TILDE) begin
            if (cursor.column >= cols_eff) begin
              nxt.row    = row_wrapped;
              nxt.column = '0;
              if (row_wrapped < rows_eff) begin
                wv = 1'b1;
                wr = row_wrapped;
                wc = '0;
                wch = item.text_byte[CHAR_W-1:0];
                nxt.column = 9'd1;
              end
            end else begin
              wv  = 1'b1;
              wr  = cursor.row;
              wc  = cursor.column;
              wch = item.text_byte[CHAR_W-1:0];
              nxt.column = cursor.column + 9'd1;
            end
          end
        end
      endcase
    end
    result.write_valid  = wv;
    result.write_row    = wr[WROW_W-1:0];
    result.write_column = wc[WCOL_W-1:0];
    result.write_char   = wch;
    result.cursor       = nxt;
    result.grid_full    = (nxt.row >= rows_eff);
  end

endmodule
